// ----- src/ara_pkg.sv -----
// Shared types, codes and sizes of the address range allocator.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none
package ara_pkg;
   localparam int REGION_SLOTS = 64;
   localparam int TOTAL_SLOTS  = 2 * REGION_SLOTS;
   localparam int IDX_W        = $clog2(TOTAL_SLOTS);
   localparam int CNT_W        = $clog2(REGION_SLOTS + 1);
   localparam int PAGE_SHIFT   = 12;
   localparam logic [63:0] PAGE_BYTES = 64'(1) << PAGE_SHIFT;
   localparam logic [63:0] PAGE_MASK  = PAGE_BYTES - 64'(1);
   localparam int CSR_COUNT    = 4;
   localparam int CSR_AW       = 5;

   typedef logic [63:0]      addr_type;
   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [15:0]      age_type;

   localparam logic [2:0] OP_RESERVE = 3'd0;
   localparam logic [2:0] OP_RELEASE = 3'd1;
   localparam logic [2:0] OP_LOOKUP  = 3'd2;
   localparam logic [2:0] OP_CARVE   = 3'd3;
   localparam logic [2:0] OP_INIT    = 3'd4;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_MISS   = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_REJECT = 2'd3;

   localparam logic [1:0] CSR_KERNEL_BASE  = 2'd0;
   localparam logic [1:0] CSR_KERNEL_LIMIT = 2'd1;
   localparam logic [1:0] CSR_USER_BASE    = 2'd2;
   localparam logic [1:0] CSR_USER_LIMIT   = 2'd3;

   typedef enum logic [1:0] {
      PASS_INIT  = 2'd0,
      PASS_SCAN  = 2'd1,
      PASS_APPLY = 2'd2,
      PASS_CARVE = 2'd3
   } pass_type;

   typedef struct packed {
      logic     ok;
      idx_type  idx;
      logic     alloc;
      logic     used;
      logic     wr_lo;
      addr_type lo;
      logic     wr_hi;
      addr_type hi;
      logic     wr_age;
   } edit_type;

   typedef struct packed {
      logic     ok;
      idx_type  idx;
      addr_type lo;
      addr_type hi;
      age_type  age;
   } hit_type;

   typedef struct packed {
      logic          valid;
      pass_type      mode;
      logic          pool;
      logic          contain;
      logic          visit_en;
      logic          excl_en;
      idx_type       excl_idx;
      addr_type      aligned;
      addr_type      probe;
      addr_type      ref_lo;
      addr_type      cut_lo;
      addr_type      cut_hi;
      age_type       age;
      edit_type [2:0] ed;
      logic          halt;
      logic          mfb_ok;
      idx_type       mfb;
      logic          seek;
      addr_type      rem_lo;
      addr_type      rem_hi;
      logic          defer_ok;
      idx_type       defer_idx;
      hit_type       fit;
      logic          free_ok;
      idx_type       free_idx;
      hit_type       used0;
      hit_type       used1;
      hit_type       left;
      hit_type       right;
      cnt_type       splits;
      cnt_type       unalloc;
   } token_type;
endpackage
`default_nettype wire

// ----- src/ara_req_if.sv -----
// Request channel of the allocator: valid/ready plus one operation.
// Depends on ara_pkg for the address type.
`default_nettype none
interface ara_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         op;
   logic               kind;
   ara_pkg::addr_type  address;
   ara_pkg::addr_type  length;
   modport source (output valid, op, kind, address, length, input ready);
   modport sink   (input valid, op, kind, address, length, output ready);
endinterface
`default_nettype wire

// ----- src/ara_rsp_if.sv -----
// Response channel of the allocator: valid/ready plus one result.
// Depends on ara_pkg for the address type.
`default_nettype none
interface ara_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   ara_pkg::addr_type  range_start;
   ara_pkg::addr_type  range_end;
   logic               range_kind;
   modport source (output valid, status, range_start, range_end, range_kind, input ready);
   modport sink   (input valid, status, range_start, range_end, range_kind, output ready);
endinterface
`default_nettype wire

// ----- src/address_range_allocator_top.sv -----
// Address range allocator: first-fit allocator of kernel and user ranges with merging.
// Channels: req_ch (op, kind, address, length) in, rsp_ch (status, range) out,
// both valid/ready; one transfer in gives exactly one transfer out.
// Registers kernel/user base and limit are written over the csr_ APB port (8-byte
// stride); they read back over that port, and only the initialize operation uses them.
// The slots live in a chain of 128 cells; an operation sends a token down the chain,
// one cell per cycle.
// Passes per successful operation: lookup 1, reserve 2, release 3,
// carve 2 plus 1 per free range it splits in the middle, initialize 1.
// Rejected arguments and unknown ops answer without launching a pass.
// One operation is in work at a time; a new request is taken while the previous
// result still waits in the output register, and held off if that result is not taken.
// Reset empties all pools (every slot unallocated) and clears the registers;
// reserve answers no fit until initialize runs.
`default_nettype none
module address_range_allocator_top (
   input  logic                        clock,
   input  logic                        reset,
   ara_req_if.sink                     req_ch,
   ara_rsp_if.source                   rsp_ch,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [ara_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [63:0]                 csr_pwdata,
   output logic [63:0]                 csr_prdata,
   output logic                        csr_pready
);
   ara_pkg::addr_type [ara_pkg::CSR_COUNT-1:0] cfg;
   ara_pkg::token_type chain [ara_pkg::TOTAL_SLOTS+1];

   ara_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .cfg_o(cfg)
   );

   ara_ctrl u_ctrl (
      .clock, .reset, .req_ch, .rsp_ch, .cfg_i(cfg),
      .ret_i(chain[ara_pkg::TOTAL_SLOTS]), .launch_o(chain[0])
   );

   for (genvar i = 0; i < ara_pkg::TOTAL_SLOTS; i++) begin : g_cell
      ara_cell u_cell (
         .clock, .reset,
         .cell_idx(ara_pkg::idx_type'(i)),
         .tok_i(chain[i]),
         .tok_o(chain[i+1])
      );
   end
endmodule
`default_nettype wire

// ----- src/ara_cell.sv -----
// One region slot of the allocator chain: holds a range and acts on the pass token.
// Depends on ara_pkg; the token moves one cell per cycle.
`default_nettype none
module ara_cell (
   input  logic                clock,
   input  logic                reset,
   input  ara_pkg::idx_type    cell_idx,
   input  ara_pkg::token_type  tok_i,
   output ara_pkg::token_type  tok_o
);
   logic alloc_ff, alloc_in, used_ff, used_in, visit_ff, visit_in;
   ara_pkg::addr_type lo_ff, lo_in, hi_ff, hi_in, os, oe;
   ara_pkg::age_type  age_ff, age_in;
   ara_pkg::token_type t, tok_ff;
   logic my_pool, in_pool, is_free, tl, tr, hit_edit, match;

   always_comb begin
      t        = tok_i;
      alloc_in = alloc_ff;
      used_in  = used_ff;
      visit_in = visit_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      age_in   = age_ff;
      hit_edit = 1'b0;
      match    = 1'b0;
      my_pool  = (cell_idx >= ara_pkg::idx_type'(ara_pkg::REGION_SLOTS));
      in_pool  = (my_pool == t.pool);
      is_free  = alloc_ff & ~used_ff;
      os       = (lo_ff > t.cut_lo) ? lo_ff : t.cut_lo;
      oe       = (hi_ff < t.cut_hi) ? hi_ff : t.cut_hi;
      tl       = (os == lo_ff);
      tr       = (oe == hi_ff);
      if (t.valid) begin
         case (t.mode)
            ara_pkg::PASS_INIT: begin
               alloc_in = 1'b0;
               used_in  = 1'b0;
               visit_in = 1'b0;
               if (cell_idx == '0 && t.ed[0].lo < t.ed[0].hi) begin
                  alloc_in = 1'b1;
                  lo_in    = t.ed[0].lo;
                  hi_in    = t.ed[0].hi;
               end
               if (cell_idx == ara_pkg::idx_type'(ara_pkg::REGION_SLOTS) &&
                   t.ed[1].lo < t.ed[1].hi) begin
                  alloc_in = 1'b1;
                  lo_in    = t.ed[1].lo;
                  hi_in    = t.ed[1].hi;
               end
            end
            ara_pkg::PASS_SCAN: begin
               if (in_pool && is_free && (hi_ff - lo_ff >= t.aligned) &&
                   (!t.fit.ok || lo_ff < t.fit.lo)) begin
                  t.fit = '{ok: 1'b1, idx: cell_idx, lo: lo_ff, hi: hi_ff, age: age_ff};
               end
               if (in_pool && !alloc_ff) begin
                  t.unalloc = t.unalloc + ara_pkg::cnt_type'(1);
                  if (!t.free_ok) begin
                     t.free_ok  = 1'b1;
                     t.free_idx = cell_idx;
                  end
               end
               match = t.contain ? (lo_ff <= t.probe && t.probe < hi_ff) : (lo_ff == t.probe);
               if (alloc_ff && used_ff && match) begin
                  if (!my_pool && (!t.used0.ok || age_ff > t.used0.age))
                     t.used0 = '{ok: 1'b1, idx: cell_idx, lo: lo_ff, hi: hi_ff, age: age_ff};
                  if (my_pool && (!t.used1.ok || age_ff > t.used1.age))
                     t.used1 = '{ok: 1'b1, idx: cell_idx, lo: lo_ff, hi: hi_ff, age: age_ff};
               end
               if (in_pool && is_free && !(t.excl_en && cell_idx == t.excl_idx)) begin
                  if (lo_ff < t.ref_lo) begin
                     if (!t.left.ok || lo_ff >= t.left.lo)
                        t.left = '{ok: 1'b1, idx: cell_idx, lo: lo_ff, hi: hi_ff, age: age_ff};
                  end else if (!t.right.ok || lo_ff < t.right.lo) begin
                     t.right = '{ok: 1'b1, idx: cell_idx, lo: lo_ff, hi: hi_ff, age: age_ff};
                  end
               end
               if (t.visit_en) begin
                  visit_in = in_pool && is_free && (os < oe);
                  if (in_pool && is_free && (os < oe) && !tl && !tr)
                     t.splits = t.splits + ara_pkg::cnt_type'(1);
               end
            end
            default: begin
               for (int k = 0; k < 3; k++) begin
                  if (t.ed[k].ok && t.ed[k].idx == cell_idx) begin
                     hit_edit = 1'b1;
                     alloc_in = t.ed[k].alloc;
                     used_in  = t.ed[k].used;
                     if (t.ed[k].wr_lo)  lo_in  = t.ed[k].lo;
                     if (t.ed[k].wr_hi)  hi_in  = t.ed[k].hi;
                     if (t.ed[k].wr_age) age_in = t.age;
                  end
               end
               if (t.mode == ara_pkg::PASS_CARVE) begin
                  if (t.seek && in_pool && !alloc_ff && !hit_edit) begin
                     alloc_in = 1'b1;
                     used_in  = 1'b0;
                     lo_in    = t.rem_lo;
                     hi_in    = t.rem_hi;
                     t.seek   = 1'b0;
                  end else if (visit_ff && !t.halt) begin
                     visit_in = 1'b0;
                     if (tl && tr) begin
                        alloc_in = 1'b0;
                        used_in  = 1'b0;
                     end else if (tl) begin
                        lo_in = oe;
                     end else if (tr) begin
                        hi_in = os;
                     end else begin
                        hi_in    = os;
                        t.halt   = 1'b1;
                        t.rem_lo = oe;
                        t.rem_hi = hi_ff;
                        if (t.mfb_ok) begin
                           t.defer_ok  = 1'b1;
                           t.defer_idx = t.mfb;
                        end else begin
                           t.seek = 1'b1;
                        end
                     end
                  end
                  if (in_pool && !alloc_in && !t.mfb_ok) begin
                     t.mfb_ok = 1'b1;
                     t.mfb    = cell_idx;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_ff     <= 1'b0;
         used_ff      <= 1'b0;
         visit_ff     <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         alloc_ff     <= alloc_in;
         used_ff      <= used_in;
         visit_ff     <= visit_in;
         tok_ff.valid <= t.valid;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      age_ff <= age_in;
      tok_ff[$bits(ara_pkg::token_type)-2:0] <= t[$bits(ara_pkg::token_type)-2:0];
   end

   assign tok_o = tok_ff;
endmodule
`default_nettype wire

// ----- src/ara_csr.sv -----
// APB-style register file for the initial kernel and user ranges.
// Depends on ara_pkg for register indexes and widths.
`default_nettype none
module ara_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [ara_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [63:0]                  csr_pwdata,
   output logic [63:0]                  csr_prdata,
   output logic                         csr_pready,
   output ara_pkg::addr_type [ara_pkg::CSR_COUNT-1:0] cfg_o
);
   ara_pkg::addr_type [ara_pkg::CSR_COUNT-1:0] cfg_ff;
   logic [1:0] sel;

   assign sel        = csr_paddr[4:3];
   assign csr_pready = 1'b1;
   assign csr_prdata = cfg_ff[sel];
   assign cfg_o      = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         cfg_ff[sel] <= csr_pwdata;
      end
   end
endmodule
`default_nettype wire

// ----- src/ara_ctrl.sv -----
// Sequencer of the allocator: checks arguments, launches passes down the cell
// chain, reads the returned token and holds the result. Depends on ara_pkg and the interfaces.
`default_nettype none
module ara_ctrl (
   input  logic                clock,
   input  logic                reset,
   ara_req_if.sink             req_ch,
   ara_rsp_if.source           rsp_ch,
   input  ara_pkg::addr_type [ara_pkg::CSR_COUNT-1:0] cfg_i,
   input  ara_pkg::token_type  ret_i,
   output ara_pkg::token_type  launch_o
);
   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_RUN  = 3'b010,
      S_FIN  = 3'b100
   } state_type;

   typedef enum logic [2:0] {
      PH_RES, PH_REL_FIND, PH_REL_NBR, PH_LOOK, PH_CARVE_SCAN, PH_CARVE, PH_APPLY
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   ara_pkg::token_type tok_ff, tok_in;
   logic kind_ff, kind_in;
   ara_pkg::addr_type addr_ff, addr_in, len_ff, len_in, cut_ff, cut_in;
   ara_pkg::addr_type sel_lo_ff, sel_lo_in, sel_hi_ff, sel_hi_in;
   ara_pkg::idx_type sel_idx_ff, sel_idx_in;
   ara_pkg::age_type age_ff, age_in;
   logic [1:0] res_st_ff, res_st_in;
   ara_pkg::addr_type res_lo_ff, res_lo_in, res_hi_ff, res_hi_in;
   logic res_kind_ff, res_kind_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_st_ff, rsp_st_in;
   ara_pkg::addr_type rsp_lo_ff, rsp_lo_in, rsp_hi_ff, rsp_hi_in;
   logic rsp_kind_ff, rsp_kind_in;
   ara_pkg::addr_type rem, base, aligned, ce;
   ara_pkg::hit_type h;
   logic ovf, lm, rm, load;

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_st_ff;
   assign rsp_ch.range_start = rsp_lo_ff;
   assign rsp_ch.range_end   = rsp_hi_ff;
   assign rsp_ch.range_kind  = rsp_kind_ff;
   assign launch_o           = tok_ff;

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      tok_in      = '0;
      kind_in     = kind_ff;
      addr_in     = addr_ff;
      len_in      = len_ff;
      cut_in      = cut_ff;
      sel_lo_in   = sel_lo_ff;
      sel_hi_in   = sel_hi_ff;
      sel_idx_in  = sel_idx_ff;
      age_in      = age_ff;
      res_st_in   = res_st_ff;
      res_lo_in   = res_lo_ff;
      res_hi_in   = res_hi_ff;
      res_kind_in = res_kind_ff;
      rem     = req_ch.length & ara_pkg::PAGE_MASK;
      base    = req_ch.length & ~ara_pkg::PAGE_MASK;
      ovf     = (rem != '0) && (base > ~ara_pkg::PAGE_BYTES);
      aligned = (rem != '0) ? base + ara_pkg::PAGE_BYTES : req_ch.length;
      ce      = req_ch.address + req_ch.length;
      h       = ret_i.used0.ok ? ret_i.used0 : ret_i.used1;
      lm      = ret_i.left.ok && ret_i.left.hi == sel_lo_ff;
      rm      = ret_i.right.ok && ret_i.right.lo == sel_hi_ff;
      load    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               kind_in     = req_ch.kind;
               addr_in     = req_ch.address;
               res_st_in   = ara_pkg::ST_REJECT;
               res_lo_in   = '0;
               res_hi_in   = '0;
               res_kind_in = 1'b0;
               state_in    = S_FIN;
               tok_in.mode  = ara_pkg::PASS_SCAN;
               tok_in.pool  = req_ch.kind;
               tok_in.probe = req_ch.address;
               case (req_ch.op)
                  ara_pkg::OP_RESERVE: begin
                     if (req_ch.length != '0 && !ovf) begin
                        len_in         = aligned;
                        tok_in.aligned = aligned;
                        tok_in.valid   = 1'b1;
                        phase_in       = PH_RES;
                        state_in       = S_RUN;
                     end
                  end
                  ara_pkg::OP_RELEASE, ara_pkg::OP_LOOKUP: begin
                     if (req_ch.address != '0) begin
                        tok_in.contain = (req_ch.op == ara_pkg::OP_LOOKUP);
                        tok_in.valid   = 1'b1;
                        phase_in = (req_ch.op == ara_pkg::OP_LOOKUP) ? PH_LOOK : PH_REL_FIND;
                        state_in = S_RUN;
                     end
                  end
                  ara_pkg::OP_CARVE: begin
                     if (req_ch.length != '0 && req_ch.length <= ~req_ch.address) begin
                        cut_in          = ce;
                        tok_in.cut_lo   = req_ch.address;
                        tok_in.cut_hi   = ce;
                        tok_in.visit_en = 1'b1;
                        tok_in.valid    = 1'b1;
                        phase_in        = PH_CARVE_SCAN;
                        state_in        = S_RUN;
                     end
                  end
                  ara_pkg::OP_INIT: begin
                     tok_in.mode     = ara_pkg::PASS_INIT;
                     tok_in.ed[0].lo = cfg_i[ara_pkg::CSR_KERNEL_BASE];
                     tok_in.ed[0].hi = cfg_i[ara_pkg::CSR_KERNEL_LIMIT];
                     tok_in.ed[1].lo = cfg_i[ara_pkg::CSR_USER_BASE];
                     tok_in.ed[1].hi = cfg_i[ara_pkg::CSR_USER_LIMIT];
                     tok_in.valid    = 1'b1;
                     age_in          = '0;
                     res_st_in       = ara_pkg::ST_OK;
                     phase_in        = PH_APPLY;
                     state_in        = S_RUN;
                  end
                  default: begin
                     res_st_in = ara_pkg::ST_REJECT;
                  end
               endcase
            end
         end
         S_RUN: begin
            if (ret_i.valid) begin
               state_in    = S_FIN;
               tok_in.pool = kind_ff;
               tok_in.age  = age_ff;
               tok_in.mode = ara_pkg::PASS_APPLY;
               case (phase_ff)
                  PH_RES: begin
                     res_st_in = ara_pkg::ST_MISS;
                     if (ret_i.fit.ok && ret_i.fit.hi - ret_i.fit.lo == len_ff) begin
                        tok_in.ed[0] = '{ok: 1'b1, idx: ret_i.fit.idx, alloc: 1'b1,
                                         used: 1'b1, wr_lo: 1'b0, lo: '0, wr_hi: 1'b0,
                                         hi: '0, wr_age: 1'b1};
                     end else if (ret_i.fit.ok && ret_i.free_ok) begin
                        tok_in.ed[0] = '{ok: 1'b1, idx: ret_i.fit.idx, alloc: 1'b1,
                                         used: 1'b0, wr_lo: 1'b1,
                                         lo: ret_i.fit.lo + len_ff, wr_hi: 1'b0,
                                         hi: '0, wr_age: 1'b0};
                        tok_in.ed[1] = '{ok: 1'b1, idx: ret_i.free_idx, alloc: 1'b1,
                                         used: 1'b1, wr_lo: 1'b1, lo: ret_i.fit.lo,
                                         wr_hi: 1'b1, hi: ret_i.fit.lo + len_ff,
                                         wr_age: 1'b1};
                     end else if (ret_i.fit.ok) begin
                        res_st_in = ara_pkg::ST_FULL;
                     end
                     if (tok_in.ed[0].ok) begin
                        tok_in.valid = 1'b1;
                        age_in       = age_ff + ara_pkg::age_type'(1);
                        res_st_in    = ara_pkg::ST_OK;
                        res_lo_in    = ret_i.fit.lo;
                        res_hi_in    = ret_i.fit.lo + len_ff;
                        res_kind_in  = kind_ff;
                        phase_in     = PH_APPLY;
                        state_in     = S_RUN;
                     end
                  end
                  PH_REL_FIND: begin
                     res_st_in = ara_pkg::ST_MISS;
                     if (h.ok) begin
                        kind_in         = !ret_i.used0.ok;
                        sel_idx_in      = h.idx;
                        sel_lo_in       = h.lo;
                        sel_hi_in       = h.hi;
                        res_st_in       = ara_pkg::ST_OK;
                        res_lo_in       = h.lo;
                        res_hi_in       = h.hi;
                        res_kind_in     = !ret_i.used0.ok;
                        tok_in.mode     = ara_pkg::PASS_SCAN;
                        tok_in.pool     = !ret_i.used0.ok;
                        tok_in.excl_en  = 1'b1;
                        tok_in.excl_idx = h.idx;
                        tok_in.ref_lo   = h.lo;
                        tok_in.valid    = 1'b1;
                        phase_in        = PH_REL_NBR;
                        state_in        = S_RUN;
                     end
                  end
                  PH_REL_NBR: begin
                     tok_in.ed[0] = '{ok: 1'b1, idx: sel_idx_ff, alloc: !lm, used: 1'b0,
                                      wr_lo: 1'b0, lo: '0, wr_hi: rm && !lm,
                                      hi: ret_i.right.hi, wr_age: 1'b0};
                     tok_in.ed[1] = '{ok: lm, idx: ret_i.left.idx, alloc: 1'b1, used: 1'b0,
                                      wr_lo: 1'b0, lo: '0, wr_hi: 1'b1,
                                      hi: rm ? ret_i.right.hi : sel_hi_ff, wr_age: 1'b0};
                     tok_in.ed[2] = '{ok: rm, idx: ret_i.right.idx, alloc: 1'b0, used: 1'b0,
                                      wr_lo: 1'b0, lo: '0, wr_hi: 1'b0, hi: '0,
                                      wr_age: 1'b0};
                     tok_in.valid = 1'b1;
                     phase_in     = PH_APPLY;
                     state_in     = S_RUN;
                  end
                  PH_LOOK: begin
                     res_st_in = ara_pkg::ST_MISS;
                     if (h.ok) begin
                        res_st_in   = ara_pkg::ST_OK;
                        res_lo_in   = h.lo;
                        res_hi_in   = h.hi;
                        res_kind_in = !ret_i.used0.ok;
                     end
                  end
                  PH_CARVE_SCAN: begin
                     if ({1'b0, ret_i.unalloc} < ({1'b0, ret_i.splits} + 1'b1)) begin
                        res_st_in = ara_pkg::ST_FULL;
                     end else begin
                        tok_in.mode   = ara_pkg::PASS_CARVE;
                        tok_in.cut_lo = addr_ff;
                        tok_in.cut_hi = cut_ff;
                        tok_in.ed[0]  = '{ok: 1'b1, idx: ret_i.free_idx, alloc: 1'b1,
                                          used: 1'b1, wr_lo: 1'b1, lo: addr_ff,
                                          wr_hi: 1'b1, hi: cut_ff, wr_age: 1'b1};
                        tok_in.valid  = 1'b1;
                        age_in        = age_ff + ara_pkg::age_type'(1);
                        res_st_in     = ara_pkg::ST_OK;
                        res_lo_in     = addr_ff;
                        res_hi_in     = cut_ff;
                        res_kind_in   = kind_ff;
                        phase_in      = PH_CARVE;
                        state_in      = S_RUN;
                     end
                  end
                  PH_CARVE: begin
                     if (ret_i.halt) begin
                        tok_in.mode   = ara_pkg::PASS_CARVE;
                        tok_in.cut_lo = addr_ff;
                        tok_in.cut_hi = cut_ff;
                        tok_in.ed[1]  = '{ok: ret_i.defer_ok, idx: ret_i.defer_idx,
                                          alloc: 1'b1, used: 1'b0, wr_lo: 1'b1,
                                          lo: ret_i.rem_lo, wr_hi: 1'b1, hi: ret_i.rem_hi,
                                          wr_age: 1'b0};
                        tok_in.valid  = 1'b1;
                        state_in      = S_RUN;
                     end
                  end
                  default: begin
                     state_in = S_FIN;
                  end
               endcase
               if (res_st_in != ara_pkg::ST_OK) begin
                  res_lo_in   = '0;
                  res_hi_in   = '0;
                  res_kind_in = 1'b0;
               end
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               load     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = load | (rsp_valid_ff & ~rsp_ch.ready);
      rsp_st_in    = load ? res_st_ff   : rsp_st_ff;
      rsp_lo_in    = load ? res_lo_ff   : rsp_lo_ff;
      rsp_hi_in    = load ? res_hi_ff   : rsp_hi_ff;
      rsp_kind_in  = load ? res_kind_ff : rsp_kind_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_APPLY;
         tok_ff       <= '0;
         age_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         tok_ff       <= tok_in;
         age_ff       <= age_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      addr_ff     <= addr_in;
      len_ff      <= len_in;
      cut_ff      <= cut_in;
      sel_lo_ff   <= sel_lo_in;
      sel_hi_ff   <= sel_hi_in;
      sel_idx_ff  <= sel_idx_in;
      res_st_ff   <= res_st_in;
      res_lo_ff   <= res_lo_in;
      res_hi_ff   <= res_hi_in;
      res_kind_ff <= res_kind_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_lo_ff   <= rsp_lo_in;
      rsp_hi_ff   <= rsp_hi_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("sequencer state not one-hot");
   a_ret_in_run: assert property (@(posedge clock) disable iff (reset)
      ret_i.valid |-> state_ff == S_RUN) else $error("token returned outside a pass");
   a_launch_run: assert property (@(posedge clock) disable iff (reset)
      tok_ff.valid |-> state_ff == S_RUN) else $error("pass launched while not running");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_st_ff != ara_pkg::ST_OK) |->
      (rsp_lo_ff == '0 && rsp_hi_ff == '0 && !rsp_kind_ff))
      else $error("failed result carries a range");
   a_halt_carve: assert property (@(posedge clock) disable iff (reset)
      (ret_i.valid && ret_i.halt) |-> phase_ff == PH_CARVE)
      else $error("split halt outside a carve pass");
endmodule
`default_nettype wire
